>>> rtl/tmt_pkg.sv
// Shared types, constants and tables of the torus mesh tessellator.
`timescale 1ns / 1ps
`default_nettype none
package tmt_pkg;

  localparam int SEG_W = 11;  // segment count and grid index width
  localparam int RW    = 30;  // divider remainder and divisor width
  localparam int QB    = 17;  // quotient bits, one divider cell each
  localparam int ZW    = 40;  // angle width ahead of the fold
  localparam int CW    = 34;  // CORDIC datapath width
  localparam int VW    = 21;  // vertex number width

  localparam logic signed [ZW-1:0] PI_Q30        = 40'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30   = 40'sd1686629713;
  localparam logic signed [ZW-1:0] THR_HALF_PI   = 40'sd5059889139;
  localparam logic signed [ZW-1:0] TWO_PI_Q30    = 40'sd6746518852;
  localparam logic signed [ZW-1:0] TWO_2PI_Q30   = 40'sd13493037704;
  localparam logic signed [ZW-1:0] FOUR_2PI_Q30  = 40'sd26986075408;
  // pi plus three turns: makes every reachable angle non-negative
  localparam logic signed [ZW-1:0] T_OFFSET      = 40'sd23612815982;
  localparam logic signed [CW-1:0] CORDIC_START  = 34'sd652032874;

  // result kinds on out_tuser
  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRI      = 2'd1;
  localparam logic [1:0] KIND_LINE     = 2'd2;
  localparam logic [1:0] KIND_LINE_END = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MAJOR_RADIUS = 3'd0;
  localparam logic [2:0] REG_TUBE_RADIUS  = 3'd1;
  localparam logic [2:0] REG_RING_SEGS    = 3'd2;
  localparam logic [2:0] REG_TUBE_SEGS    = 3'd3;
  localparam logic [2:0] REG_RING_START   = 3'd4;
  localparam logic [2:0] REG_RING_SPAN    = 3'd5;
  localparam logic [2:0] REG_TUBE_START   = 3'd6;
  localparam logic [2:0] REG_TUBE_SPAN    = 3'd7;

  // divider lanes
  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_S = 2;
  localparam int LANE_T = 3;

  typedef struct packed {
    logic                    act;
    logic [SEG_W-1:0]        j;
    logic [SEG_W-1:0]        i;
    logic [SEG_W-1:0]        rs;
    logic [SEG_W-1:0]        ts;
    logic [SEG_W:0]          wdt;
    logic [22:0]             wj;
    logic signed [27:0]      pu;
    logic signed [27:0]      pv;
    logic [3:0][RW-1:0]      rem;
    logic [3:0][RW-1:0]      den;
    logic [3:0][QB-1:0]      quo;
    logic [1:0]              neg;
    logic signed [ZW-1:0]    tu;
    logic signed [ZW-1:0]    tv;
    logic                    flipu;
    logic                    flipv;
    logic signed [CW-1:0]    xu;
    logic signed [CW-1:0]    yu;
    logic signed [CW-1:0]    zu;
    logic signed [CW-1:0]    xv;
    logic signed [CW-1:0]    yv;
    logic signed [CW-1:0]    zv;
    logic [15:0]             tex_s;
    logic [15:0]             tex_t;
    logic signed [CW-1:0]    cu;
    logic signed [CW-1:0]    su;
    logic signed [CW-1:0]    sv;
    logic signed [50:0]      mw;
    logic signed [50:0]      mz;
    logic signed [67:0]      n3;
    logic signed [67:0]      n4;
    logic signed [35:0]      wr;
    logic signed [15:0]      pz;
    logic signed [15:0]      nx;
    logic signed [15:0]      ny;
    logic signed [15:0]      nz;
    logic signed [69:0]      px_p;
    logic signed [69:0]      py_p;
  } item_t;

  typedef struct packed {
    logic                act;
    logic                i_one;
    logic signed [15:0]  px;
    logic signed [15:0]  py;
    logic signed [15:0]  pz;
    logic signed [15:0]  nx;
    logic signed [15:0]  ny;
    logic signed [15:0]  nz;
    logic [15:0]         tex_s;
    logic [15:0]         tex_t;
    logic [VW-1:0]       va;
    logic [VW-1:0]       vb;
    logic [VW-1:0]       vc;
    logic [VW-1:0]       vd;
  } seq_in_t;

  // atan(2^-k) in Q4.30, series sum with truncated terms
  function automatic logic signed [CW-1:0] atan_q30(input int k);
    logic signed [CW-1:0] v;
    case (k)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837830;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525158;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388438;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097150;
      default: v = CW'(64'sd1 <<< (30 - k));
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tmt_div_cell.sv
// One restoring-division cell: settles one quotient bit on all four lanes.
`timescale 1ns / 1ps
`default_nettype none
module tmt_div_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire tmt_pkg::item_t in_item,
  output logic                out_vld,
  output tmt_pkg::item_t      out_item
);

  tmt_pkg::item_t item_nxt;
  logic           vld_r;
  tmt_pkg::item_t item_r;

  always_comb begin
    logic [tmt_pkg::RW-1:0] trial;
    item_nxt = in_item;
    for (int l = 0; l < 4; l++) begin
      trial = in_item.den[l] << SHIFT;
      if (in_item.rem[l] >= trial) begin
        item_nxt.rem[l] = in_item.rem[l] - trial;
        item_nxt.quo[l][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

>>> rtl/tmt_cordic_cell.sv
// One CORDIC rotation cell for the ring and tube angles.
`timescale 1ns / 1ps
`default_nettype none
module tmt_cordic_cell #(
  parameter int K = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire tmt_pkg::item_t in_item,
  output logic                out_vld,
  output tmt_pkg::item_t      out_item
);

  localparam logic signed [tmt_pkg::CW-1:0] ATAN_K = tmt_pkg::atan_q30(K);

  tmt_pkg::item_t item_nxt;
  logic           vld_r;
  tmt_pkg::item_t item_r;

  always_comb begin
    item_nxt = in_item;
    if (in_item.zu >= 0) begin
      item_nxt.xu = in_item.xu - (in_item.yu >>> K);
      item_nxt.yu = in_item.yu + (in_item.xu >>> K);
      item_nxt.zu = in_item.zu - ATAN_K;
    end else begin
      item_nxt.xu = in_item.xu + (in_item.yu >>> K);
      item_nxt.yu = in_item.yu - (in_item.xu >>> K);
      item_nxt.zu = in_item.zu + ATAN_K;
    end
    if (in_item.zv >= 0) begin
      item_nxt.xv = in_item.xv - (in_item.yv >>> K);
      item_nxt.yv = in_item.yv + (in_item.xv >>> K);
      item_nxt.zv = in_item.zv - ATAN_K;
    end else begin
      item_nxt.xv = in_item.xv + (in_item.yv >>> K);
      item_nxt.yv = in_item.yv - (in_item.xv >>> K);
      item_nxt.zv = in_item.zv + ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

>>> rtl/tmt_out_seq.sv
// Output sequencer: one beat per vertex, the triangle and line run per quad.
`timescale 1ns / 1ps
`default_nettype none
module tmt_out_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire tmt_pkg::seq_in_t in_item,
  output logic                  take,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // kind
  output logic [1:0]            out_tuser,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, vert_a, vert_b, vert_c
  output logic [191:0]          out_tdata
);

  typedef enum logic [2:0] {
    ST_TRI0,
    ST_TRI1,
    ST_LINE_AB,
    ST_LINE_BC,
    ST_LINE_CD,
    ST_LINE_DA
  } step_t;

  logic             busy_r;
  step_t            step_r;
  step_t            step_nxt;
  tmt_pkg::seq_in_t hold_r;
  logic             last_beat;

  logic [1:0]                kind;
  logic [127:0]              attr;
  logic [tmt_pkg::VW-1:0]    va, vb, vc;

  assign last_beat = !hold_r.act || (step_r == ST_LINE_DA);
  assign take      = !busy_r || (out_tready && last_beat);

  always_comb begin
    case (step_r)
      ST_TRI0:    step_nxt = ST_TRI1;
      ST_TRI1:    step_nxt = hold_r.i_one ? ST_LINE_AB : ST_LINE_BC;
      ST_LINE_AB: step_nxt = ST_LINE_BC;
      ST_LINE_BC: step_nxt = ST_LINE_CD;
      ST_LINE_CD: step_nxt = ST_LINE_DA;
      default:    step_nxt = ST_LINE_DA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_TRI0;
    end else if (take) begin
      busy_r <= in_vld;
      step_r <= ST_TRI0;
      hold_r <= in_item;
    end else if (out_tready) begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    kind = tmt_pkg::KIND_TRI;
    attr = '0;
    va   = '0;
    vb   = '0;
    vc   = '0;
    if (!hold_r.act) begin
      kind = tmt_pkg::KIND_VERTEX;
      attr = {hold_r.tex_t, hold_r.tex_s, hold_r.nz, hold_r.ny, hold_r.nx,
              hold_r.pz, hold_r.py, hold_r.px};
    end else begin
      case (step_r)
        ST_TRI0: begin
          va = hold_r.va; vb = hold_r.vb; vc = hold_r.vd;
        end
        ST_TRI1: begin
          va = hold_r.vb; vb = hold_r.vc; vc = hold_r.vd;
        end
        ST_LINE_AB: begin
          kind = tmt_pkg::KIND_LINE; va = hold_r.va; vb = hold_r.vb;
        end
        ST_LINE_BC: begin
          kind = tmt_pkg::KIND_LINE; va = hold_r.vb; vb = hold_r.vc;
        end
        ST_LINE_CD: begin
          kind = tmt_pkg::KIND_LINE; va = hold_r.vc; vb = hold_r.vd;
        end
        default: begin
          kind = tmt_pkg::KIND_LINE_END; va = hold_r.vd; vb = hold_r.va;
        end
      endcase
    end
  end

  assign out_tvalid = busy_r;
  assign out_tuser  = kind;
  assign out_tdata  = {1'b0, vc, vb, va, attr};

  a_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_tready |=> $stable(step_r) && busy_r)
    else $error("step moved while the beat was stalled");

  a_vertex_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !hold_r.act |-> step_r == ST_TRI0)
    else $error("vertex item left the first step");

  a_vertex_no_verts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tmt_pkg::KIND_VERTEX |-> out_tdata[191:128] == '0)
    else $error("vertex beat carries vertex numbers");

  a_prim_no_attr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tmt_pkg::KIND_VERTEX |-> out_tdata[127:0] == '0)
    else $error("primitive beat carries vertex attributes");

endmodule
`default_nettype wire

>>> rtl/torus_mesh_tessellator_core.sv
// Top level of the torus mesh tessellator: configuration, pipeline and output.
// A vertex request (in_tuser 0) returns one vertex beat and the pipeline takes one
// request every cycle while out_tready is high; a quad request (in_tuser 1) returns
// five or six beats and keeps the output sequencer busy for all of them, so the input
// stalls for all but the last of them while a finished item waits behind it. From
// acceptance to the first beat an item passes three setup stages, a chain of 17
// divider cells (one quotient bit each), five angle reduction stages, one CORDIC cell
// per SINCOS_STAGES, four multiply and round stages and the output register.
// Requests outside the grid and quads at index zero are dropped without a beat.
`timescale 1ns / 1ps
`default_nettype none
module torus_mesh_tessellator_core #(
  parameter int MAX_SEGMENTS  = 1024,
  parameter int SINCOS_STAGES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // ring_index, tube_index
  input  wire logic [23:0]  in_tdata,
  // action
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, vert_a, vert_b, vert_c
  output logic [191:0]      out_tdata,
  // kind
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int SW = tmt_pkg::SEG_W;
  localparam int QB = tmt_pkg::QB;

  logic [15:0]        major_r, tube_r;
  logic [SW-1:0]      rsegs_r, tsegs_r;
  logic signed [15:0] rstart_r, rspan_r, tstart_r, tspan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r  <= 16'd256;
      tube_r   <= 16'd102;
      rsegs_r  <= 11'd32;
      tsegs_r  <= 11'd16;
      rstart_r <= 16'sd0;
      rspan_r  <= 16'sd25736;
      tstart_r <= 16'sd0;
      tspan_r  <= 16'sd25736;
    end else if (cfg_we) begin
      case (cfg_index)
        tmt_pkg::REG_MAJOR_RADIUS: major_r  <= cfg_wdata;
        tmt_pkg::REG_TUBE_RADIUS:  tube_r   <= cfg_wdata;
        tmt_pkg::REG_RING_SEGS:    rsegs_r  <= cfg_wdata[SW-1:0];
        tmt_pkg::REG_TUBE_SEGS:    tsegs_r  <= cfg_wdata[SW-1:0];
        tmt_pkg::REG_RING_START:   rstart_r <= cfg_wdata;
        tmt_pkg::REG_RING_SPAN:    rspan_r  <= cfg_wdata;
        tmt_pkg::REG_TUBE_START:   tstart_r <= cfg_wdata;
        tmt_pkg::REG_TUBE_SPAN:    tspan_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] eff_segs(input logic [SW-1:0] raw);
    logic [SW-1:0] v;
    if (raw == '0) begin
      v = SW'(1);
    end else if (int'(raw) > MAX_SEGMENTS) begin
      v = SW'(MAX_SEGMENTS);
    end else begin
      v = raw;
    end
    return v;
  endfunction

  function automatic logic signed [71:0] rnd72(input logic signed [71:0] v, input int k);
    return (v + (72'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [15:0] sat_pos(input logic signed [71:0] v);
    logic signed [15:0] r;
    if (v > 72'sd32767) r = 16'sd32767;
    else if (v < -72'sd32768) r = -16'sd32768;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic signed [15:0] sat_norm(input logic signed [71:0] v);
    logic signed [15:0] r;
    if (v > 72'sd16384) r = 16'sd16384;
    else if (v < -72'sd16384) r = -16'sd16384;
    else r = 16'(v);
    return r;
  endfunction

  logic [SW-1:0] rs_eff, ts_eff;
  assign rs_eff = eff_segs(rsegs_r);
  assign ts_eff = eff_segs(tsegs_r);

  logic en;
  logic seq_take;

  logic           a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r;
  logic           m1_vld_r, m2_vld_r, m3_vld_r, sq_vld_r;
  tmt_pkg::item_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r, m1_r, m2_r, m3_r;
  tmt_pkg::item_t a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt;
  tmt_pkg::item_t m1_nxt, m2_nxt, m3_nxt;
  tmt_pkg::seq_in_t sq_r, sq_nxt;
  logic           a_vld_nxt;

  tmt_pkg::item_t dv_item [QB+1];
  logic           dv_vld  [QB+1];
  tmt_pkg::item_t cd_item [SINCOS_STAGES+1];
  logic           cd_vld  [SINCOS_STAGES+1];

  // advance the whole pipe unless a finished item waits at the sequencer
  assign en        = !sq_vld_r || seq_take;
  assign in_tready = en;

  // request capture and range check
  always_comb begin
    logic [SW-1:0] j, i;
    j = in_tdata[SW-1:0];
    i = in_tdata[2*SW-1:SW];
    a_nxt     = '0;
    a_nxt.act = in_tuser;
    a_nxt.j   = j;
    a_nxt.i   = i;
    a_nxt.rs  = rs_eff;
    a_nxt.ts  = ts_eff;
    a_vld_nxt = in_tvalid && (j <= rs_eff) && (i <= ts_eff) &&
                !(in_tuser && (j == '0 || i == '0));
  end

  // index times span, grid width times row
  always_comb begin
    logic [SW:0] wdt;
    b_nxt    = a_r;
    wdt      = {1'b0, a_r.ts} + (SW+1)'(1);
    b_nxt.wdt = wdt;
    b_nxt.wj = 23'(wdt) * 23'(a_r.j);
    b_nxt.pu = $signed({1'b0, a_r.j}) * rspan_r;
    b_nxt.pv = $signed({1'b0, a_r.i}) * tspan_r;
  end

  // dividend magnitudes and divisors for the four lanes
  always_comb begin
    logic signed [tmt_pkg::RW-1:0] nu, nv;
    c_nxt = b_r;
    nu = (tmt_pkg::RW'(b_r.pu) <<< 1) + $signed({19'b0, b_r.rs});
    nv = (tmt_pkg::RW'(b_r.pv) <<< 1) + $signed({19'b0, b_r.ts});
    c_nxt.neg[tmt_pkg::LANE_U] = nu < 0;
    c_nxt.neg[tmt_pkg::LANE_V] = nv < 0;
    c_nxt.rem[tmt_pkg::LANE_U] = (nu < 0) ? $unsigned(-nu) : $unsigned(nu);
    c_nxt.rem[tmt_pkg::LANE_V] = (nv < 0) ? $unsigned(-nv) : $unsigned(nv);
    c_nxt.rem[tmt_pkg::LANE_S] = {3'b0, b_r.i, 16'b0} + {19'b0, b_r.ts};
    c_nxt.rem[tmt_pkg::LANE_T] = {3'b0, b_r.j, 16'b0} + {19'b0, b_r.rs};
    c_nxt.den[tmt_pkg::LANE_U] = {18'b0, b_r.rs, 1'b0};
    c_nxt.den[tmt_pkg::LANE_V] = {18'b0, b_r.ts, 1'b0};
    c_nxt.den[tmt_pkg::LANE_S] = {18'b0, b_r.ts, 1'b0};
    c_nxt.den[tmt_pkg::LANE_T] = {18'b0, b_r.rs, 1'b0};
    c_nxt.quo = '0;
  end

  assign dv_item[0] = c_r;
  assign dv_vld[0]  = c_vld_r;

  for (genvar n = 0; n < QB; n++) begin : g_div
    tmt_div_cell #(.SHIFT(QB - 1 - n)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (dv_vld[n]),
      .in_item  (dv_item[n]),
      .out_vld  (dv_vld[n+1]),
      .out_item (dv_item[n+1])
    );
  end

  // floor the quotient, add the start angle, scale and offset
  always_comb begin
    tmt_pkg::item_t  q;
    logic [QB:0]     qa_u, qa_v;
    logic signed [QB+1:0] qf_u, qf_v, ang_u, ang_v;
    q     = dv_item[QB];
    d_nxt = q;
    qa_u  = {1'b0, q.quo[tmt_pkg::LANE_U]} +
            (QB+1)'(q.neg[tmt_pkg::LANE_U] && q.rem[tmt_pkg::LANE_U] != '0);
    qa_v  = {1'b0, q.quo[tmt_pkg::LANE_V]} +
            (QB+1)'(q.neg[tmt_pkg::LANE_V] && q.rem[tmt_pkg::LANE_V] != '0);
    qf_u  = q.neg[tmt_pkg::LANE_U] ? -$signed({1'b0, qa_u}) : $signed({1'b0, qa_u});
    qf_v  = q.neg[tmt_pkg::LANE_V] ? -$signed({1'b0, qa_v}) : $signed({1'b0, qa_v});
    ang_u = (QB+2)'(rstart_r) + qf_u;
    ang_v = (QB+2)'(tstart_r) + qf_v;
    d_nxt.tu = (tmt_pkg::ZW'(ang_u) <<< 18) + tmt_pkg::T_OFFSET;
    d_nxt.tv = (tmt_pkg::ZW'(ang_v) <<< 18) + tmt_pkg::T_OFFSET;
    d_nxt.tex_s = q.quo[tmt_pkg::LANE_S][15:0];
    d_nxt.tex_t = q.quo[tmt_pkg::LANE_T][15:0];
  end

  // remove whole turns: four, two, then one
  always_comb begin
    e_nxt = d_r;
    if (d_r.tu >= tmt_pkg::FOUR_2PI_Q30) e_nxt.tu = d_r.tu - tmt_pkg::FOUR_2PI_Q30;
    if (d_r.tv >= tmt_pkg::FOUR_2PI_Q30) e_nxt.tv = d_r.tv - tmt_pkg::FOUR_2PI_Q30;
  end

  always_comb begin
    f_nxt = e_r;
    if (e_r.tu >= tmt_pkg::TWO_2PI_Q30) f_nxt.tu = e_r.tu - tmt_pkg::TWO_2PI_Q30;
    if (e_r.tv >= tmt_pkg::TWO_2PI_Q30) f_nxt.tv = e_r.tv - tmt_pkg::TWO_2PI_Q30;
  end

  always_comb begin
    g_nxt = f_r;
    if (f_r.tu >= tmt_pkg::TWO_PI_Q30) g_nxt.tu = f_r.tu - tmt_pkg::TWO_PI_Q30;
    if (f_r.tv >= tmt_pkg::TWO_PI_Q30) g_nxt.tv = f_r.tv - tmt_pkg::TWO_PI_Q30;
  end

  // fold into the right half plane; the angle is t - pi with t in [0, 2pi)
  always_comb begin
    logic signed [tmt_pkg::ZW-1:0] zu, zv;
    h_nxt = g_r;
    h_nxt.flipu = 1'b1;
    h_nxt.flipv = 1'b1;
    if (g_r.tu > tmt_pkg::THR_HALF_PI) begin
      zu = tmt_pkg::TWO_PI_Q30 - g_r.tu;
    end else if (g_r.tu < tmt_pkg::HALF_PI_Q30) begin
      zu = -g_r.tu;
    end else begin
      zu = g_r.tu - tmt_pkg::PI_Q30;
      h_nxt.flipu = 1'b0;
    end
    if (g_r.tv > tmt_pkg::THR_HALF_PI) begin
      zv = tmt_pkg::TWO_PI_Q30 - g_r.tv;
    end else if (g_r.tv < tmt_pkg::HALF_PI_Q30) begin
      zv = -g_r.tv;
    end else begin
      zv = g_r.tv - tmt_pkg::PI_Q30;
      h_nxt.flipv = 1'b0;
    end
    h_nxt.zu = tmt_pkg::CW'(zu);
    h_nxt.zv = tmt_pkg::CW'(zv);
    h_nxt.xu = tmt_pkg::CORDIC_START;
    h_nxt.xv = tmt_pkg::CORDIC_START;
    h_nxt.yu = '0;
    h_nxt.yv = '0;
  end

  assign cd_item[0] = h_r;
  assign cd_vld[0]  = h_vld_r;

  for (genvar k = 0; k < SINCOS_STAGES; k++) begin : g_cordic
    tmt_cordic_cell #(.K(k)) u_cordic (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (cd_vld[k]),
      .in_item  (cd_item[k]),
      .out_vld  (cd_vld[k+1]),
      .out_item (cd_item[k+1])
    );
  end

  // first products
  always_comb begin
    tmt_pkg::item_t s;
    logic signed [tmt_pkg::CW-1:0] cu, cv;
    s  = cd_item[SINCOS_STAGES];
    cu = s.flipu ? -s.xu : s.xu;
    cv = s.flipv ? -s.xv : s.xv;
    m1_nxt    = s;
    m1_nxt.cu = cu;
    m1_nxt.su = s.yu;
    m1_nxt.sv = s.yv;
    m1_nxt.mw = $signed({1'b0, tube_r}) * cv;
    m1_nxt.mz = $signed({1'b0, tube_r}) * s.yv;
    m1_nxt.n3 = cv * cu;
    m1_nxt.n4 = cv * s.yu;
  end

  // ring radius at this tube angle, z and normal rounding
  always_comb begin
    logic signed [51:0] w;
    m2_nxt = m1_r;
    w  = 52'($signed({1'b0, major_r, 30'b0})) + 52'(m1_r.mw);
    m2_nxt.wr = 36'(rnd72(72'(w), 16));
    m2_nxt.pz = sat_pos(rnd72(72'(m1_r.mz), 30));
    m2_nxt.nx = sat_norm(rnd72(72'(m1_r.n3), 46));
    m2_nxt.ny = sat_norm(rnd72(72'(m1_r.n4), 46));
    m2_nxt.nz = sat_norm(rnd72(72'(m1_r.sv), 16));
  end

  always_comb begin
    m3_nxt      = m2_r;
    m3_nxt.px_p = m2_r.wr * m2_r.cu;
    m3_nxt.py_p = m2_r.wr * m2_r.su;
  end

  // final rounding and quad corner numbers
  always_comb begin
    logic [23:0] base;
    base = 24'(m3_r.wj) + 24'(m3_r.i);
    sq_nxt.act   = m3_r.act;
    sq_nxt.i_one = (m3_r.i == SW'(1));
    sq_nxt.px    = sat_pos(rnd72(72'(m3_r.px_p), 44));
    sq_nxt.py    = sat_pos(rnd72(72'(m3_r.py_p), 44));
    sq_nxt.pz    = m3_r.pz;
    sq_nxt.nx    = m3_r.nx;
    sq_nxt.ny    = m3_r.ny;
    sq_nxt.nz    = m3_r.nz;
    sq_nxt.tex_s = m3_r.tex_s;
    sq_nxt.tex_t = m3_r.tex_t;
    sq_nxt.va    = tmt_pkg::VW'(base - 24'd1);
    sq_nxt.vb    = tmt_pkg::VW'(base - 24'(m3_r.wdt) - 24'd1);
    sq_nxt.vc    = tmt_pkg::VW'(base - 24'(m3_r.wdt));
    sq_nxt.vd    = tmt_pkg::VW'(base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
      d_vld_r  <= 1'b0;
      e_vld_r  <= 1'b0;
      f_vld_r  <= 1'b0;
      g_vld_r  <= 1'b0;
      h_vld_r  <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r  <= a_vld_nxt;
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
      d_vld_r  <= dv_vld[QB];
      e_vld_r  <= d_vld_r;
      f_vld_r  <= e_vld_r;
      g_vld_r  <= f_vld_r;
      h_vld_r  <= g_vld_r;
      m1_vld_r <= cd_vld[SINCOS_STAGES];
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      sq_vld_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= c_nxt;
      d_r  <= d_nxt;
      e_r  <= e_nxt;
      f_r  <= f_nxt;
      g_r  <= g_nxt;
      h_r  <= h_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      sq_r <= sq_nxt;
    end
  end

  tmt_out_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (sq_vld_r),
    .in_item    (sq_r),
    .take       (seq_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
